// File: design/sard_pkg.sv
package sard_pkg;

	localparam int LOG_DEPTH = 256;
	localparam int ADDR_W = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int RACE_W = $clog2(LOG_DEPTH * (LOG_DEPTH - 1) / 2 + 1);

	localparam int ACT_W = 2;
	localparam int RES_W = 64;
	localparam int THR_W = 32;
	localparam int KIND_W = 2;
	localparam int CAP_W = 9;
	localparam int NEWR_W = 15;
	localparam int USED_W = 9;
	localparam int CTR_W = 32;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam int IN_TDATA_W = 136;
	localparam int IN_TUSER_W = ACT_W;
	localparam int OUT_TDATA_W = 128;

	localparam logic [ACT_W-1:0] ACT_TRACK = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRICT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef struct packed {
		logic load;
		logic start;
		logic refuse;
		logic clear_count;
		logic scan;
		logic write;
		logic fetch;
		logic outer_hit;
		logic outer_skip;
		logic inner;
		logic commit;
		logic out_load;
	} sard_cmd_t;

	typedef struct packed {
		logic is_track;
		logic is_query;
		logic is_clear;
		logic enabled;
		logic strict;
		logic full;
		logic cnt_zero;
		logic cnt_ge2;
		logic scan_last;
		logic outer_match;
		logic i_avail;
		logic i_next_avail;
		logic out_free;
	} sard_stat_t;

endpackage

// File: design/sard_datapath.sv
module sard_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sard_pkg::sard_cmd_t                 cmd,
	output sard_pkg::sard_stat_t                stat,
	input  logic [sard_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [sard_pkg::IN_TUSER_W-1:0]     s_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sard_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sard_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sard_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import sard_pkg::*;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [RES_W-1:0] res_mem [LOG_DEPTH];
	logic [THR_W-1:0] thr_mem [LOG_DEPTH];
	logic             wr_mem  [LOG_DEPTH];

	logic [RES_W-1:0] rd_res_q;
	logic [THR_W-1:0] rd_thr_q;
	logic             rd_wr_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [ACT_W-1:0] act_q;
	logic [RES_W-1:0] res_q;
	logic [THR_W-1:0] t1_q;
	logic [THR_W-1:0] t2_q;
	logic             wr_q;

	logic [RES_W-1:0] hold_res_q;
	logic             hold_wr_q;

	logic             enabled_q;
	logic             strict_q;
	logic [CAP_W-1:0] cap_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  i_q;
	logic [RACE_W-1:0] races_q;
	logic              acc_q;
	logic              cmp_v_s1;
	logic              cmp_qry_s1;

	logic [CTR_W-1:0] access_q;
	logic [CTR_W-1:0] error_q;
	logic [CTR_W-1:0] race_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             trk_hit;
	logic             qry_hit;
	logic             hit;
	logic             found;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			strict_q  <= 1'b0;
			cap_q     <= CAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLED:  enabled_q <= cfg_data[0];
				CFG_STRICT:   strict_q  <= cfg_data[0];
				CFG_CAPACITY: cap_q     <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser;
			res_q <= s_tdata[63:0];
			t1_q  <= s_tdata[95:64];
			t2_q  <= s_tdata[127:96];
			wr_q  <= (s_tdata[129:128] == KIND_WRITE);
		end
	end

	assign rd_addr = cmd.fetch ? i_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			res_mem[count_q[ADDR_W-1:0]] <= res_q;
			thr_mem[count_q[ADDR_W-1:0]] <= t1_q;
			wr_mem[count_q[ADDR_W-1:0]]  <= wr_q;
		end
		rd_res_q <= res_mem[rd_addr];
		rd_thr_q <= thr_mem[rd_addr];
		rd_wr_q  <= wr_mem[rd_addr];
	end

	assign trk_hit = (rd_res_q == res_q) && (rd_thr_q != t1_q) && (wr_q || rd_wr_q);
	assign qry_hit = (rd_thr_q == t2_q) && (rd_res_q == hold_res_q) && (hold_wr_q || rd_wr_q);
	assign hit = cmp_v_s1 && (cmp_qry_s1 ? qry_hit : trk_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.scan || cmd.inner;
		end
	end

	always_ff @(posedge clk) begin
		cmp_qry_s1 <= cmd.inner;
		if (cmd.start) begin
			races_q <= '0;
			idx_q   <= '0;
			i_q     <= '0;
		end else begin
			races_q <= races_q + RACE_W'(hit);
			if (cmd.outer_hit) begin
				idx_q      <= i_q + CNT_W'(1);
				hold_res_q <= rd_res_q;
				hold_wr_q  <= rd_wr_q;
			end else if (cmd.scan || cmd.inner) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.outer_hit || cmd.outer_skip) begin
				i_q <= i_q + CNT_W'(1);
			end
		end
		if (cmd.refuse) begin
			acc_q <= 1'b0;
		end else if (cmd.start) begin
			acc_q <= (act_q == ACT_TRACK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			access_q <= '0;
			error_q  <= '0;
			race_q   <= '0;
		end else begin
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.write) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.write) begin
				access_q <= access_q + CTR_W'(1);
			end
			if (cmd.refuse) begin
				error_q <= error_q + CTR_W'(1);
			end
			if (cmd.write || cmd.commit) begin
				race_q <= race_q + CTR_W'(races_q);
			end
		end
	end

	// effective capacity clamped to 1..LOG_DEPTH
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		eff_cap = cap_ext;
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end
		if (cap_ext > CMP_W'(LOG_DEPTH)) begin
			eff_cap = CMP_W'(LOG_DEPTH);
		end
	end

	always_comb begin
		stat.is_track     = (act_q == ACT_TRACK);
		stat.is_query     = (act_q == ACT_QUERY);
		stat.is_clear     = (act_q == ACT_CLEAR);
		stat.enabled      = enabled_q;
		stat.strict       = strict_q;
		stat.full         = (CMP_W'(count_q) >= eff_cap);
		stat.cnt_zero     = (count_q == '0);
		stat.cnt_ge2      = ({1'b0, count_q} >= (CNT_W+1)'(2));
		stat.scan_last    = (({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, count_q});
		stat.outer_match  = (rd_thr_q == t1_q);
		stat.i_avail      = (({1'b0, i_q} + (CNT_W+1)'(1)) < {1'b0, count_q});
		stat.i_next_avail = (({1'b0, i_q} + (CNT_W+1)'(2)) < {1'b0, count_q});
		stat.out_free     = !m_tvalid_q || m_tready;
	end

	assign found = (act_q == ACT_QUERY) && (races_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= OUT_TDATA_W'({race_q, error_q, access_q, USED_W'(count_q),
				NEWR_W'(races_q), found, acc_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: design/sard_ctrl.sv
module sard_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sard_pkg::sard_stat_t stat,
	output sard_pkg::sard_cmd_t  cmd
);
	import sard_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DECODE = 11'b000_0000_0010,
		S_TSCAN  = 11'b000_0000_0100,
		S_TDRAIN = 11'b000_0000_1000,
		S_TWRITE = 11'b000_0001_0000,
		S_QFETCH = 11'b000_0010_0000,
		S_QCHECK = 11'b000_0100_0000,
		S_QINNER = 11'b000_1000_0000,
		S_QDRAIN = 11'b001_0000_0000,
		S_QEND   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.start = 1'b1;
				state_nxt = S_DONE;
				if (stat.is_track) begin
					if (stat.enabled) begin
						if (stat.full) begin
							if (stat.strict) begin
								cmd.refuse = 1'b1;
							end else begin
								cmd.clear_count = 1'b1;
								state_nxt = S_TWRITE;
							end
						end else if (stat.cnt_zero) begin
							state_nxt = S_TWRITE;
						end else begin
							state_nxt = S_TSCAN;
						end
					end
				end else if (stat.is_query) begin
					if (stat.enabled && stat.cnt_ge2) begin
						state_nxt = S_QFETCH;
					end
				end else if (stat.is_clear) begin
					cmd.clear_count = 1'b1;
				end
			end
			S_TSCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_TDRAIN;
				end
			end
			S_TDRAIN: begin
				state_nxt = S_TWRITE;
			end
			S_TWRITE: begin
				cmd.write = 1'b1;
				state_nxt = S_DONE;
			end
			S_QFETCH: begin
				cmd.fetch = 1'b1;
				state_nxt = S_QCHECK;
			end
			S_QCHECK: begin
				if (stat.outer_match) begin
					cmd.outer_hit = 1'b1;
					state_nxt = S_QINNER;
				end else begin
					cmd.outer_skip = 1'b1;
					state_nxt = stat.i_next_avail ? S_QFETCH : S_QEND;
				end
			end
			S_QINNER: begin
				cmd.inner = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_QDRAIN;
				end
			end
			S_QDRAIN: begin
				// last inner compare lands here; next outer read overlaps it
				if (stat.i_avail) begin
					cmd.fetch = 1'b1;
					state_nxt = S_QCHECK;
				end else begin
					state_nxt = S_QEND;
				end
			end
			S_QEND: begin
				cmd.commit = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// File: design/shared_access_race_detector.sv
// Shared-access race detector.
// Input stream (s_*): one transaction per action. tuser carries the action
// (track, query, clear); tdata carries resource, thread, other thread and
// access kind. Output stream (m_*): one result transaction per input.
// Config channel (cfg_*): index and data, always ready; write only when idle.
// Paths per transaction, n = entries in the log; the result becomes valid
// in the same cycle that s_tready returns high:
//   track, n > 0, log not full: log scan, one entry compared per cycle, write
//   track on an empty log or on a full non-strict log: write, no scan
//   clear, refused or disabled track, disabled query, query with n < 2: no scan
//   query, n >= 2: each outer entry up to entry n-2 is read and, for each
//     outer entry matching the first thread, the entries after it are
//     compared.
// One transaction at a time; s_tready is high only while the controller
// idles. The result sits in an output register, so the next transaction is
// taken while a result still waits on m_tready. A stalled receiver holds the
// finished result and the controller waits until the register frees.
// Reset clears the log count, the access, error and race totals and the
// output valid; config returns to enabled, non-strict, capacity 256. Log RAM
// contents are not cleared: only entries below the count are read.
module shared_access_race_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// res_id[63:0], thr_id[95:64], other_thr[127:96],
	// access_kind[129:128], zero pad
	input  logic [sard_pkg::IN_TDATA_W-1:0]     s_tdata,
	// action[1:0]
	input  logic [sard_pkg::IN_TUSER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted[0], race_found[1], new_races[16:2], entries_used[25:17],
	// total_accesses[57:26], error_total[89:58], race_total[121:90], zero pad
	output logic [sard_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sard_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sard_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sard_pkg::*;

	sard_cmd_t  cmd;
	sard_stat_t stat;

	sard_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sard_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: design/sard_checker.sv
module sard_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [sard_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import sard_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("accepted and race_found both set");

	a_races_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[16:2] != '0) |-> m_tdata[0] || m_tdata[1])
		else $error("races reported without track or query");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:17] <= USED_W'(LOG_DEPTH))
		else $error("entries_used beyond log depth");

endmodule

bind shared_access_race_detector sard_checker u_sard_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
